// ----- rtl/alu8f_pkg.sv -----
package alu8f_pkg;

  // Operation codes, in the order of the instruction list
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_RLCA = 5'd10,
    OP_RRCA = 5'd11,
    OP_RRA  = 5'd12,
    OP_RLC  = 5'd13,
    OP_RRC  = 5'd14,
    OP_RL   = 5'd15,
    OP_RR   = 5'd16,
    OP_SLA  = 5'd17,
    OP_SRA  = 5'd18,
    OP_SRL  = 5'd19,
    OP_SWAP = 5'd20,
    OP_BIT  = 5'd21,
    OP_RES  = 5'd22,
    OP_SET  = 5'd23,
    OP_DAA  = 5'd24,
    OP_CPL  = 5'd25,
    OP_SCF  = 5'd26,
    OP_CCF  = 5'd27
  } alu_op_t;

  // Flag positions within the 4-bit flag word
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust constants
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_LIMIT  = 8'h99;
  localparam logic [3:0] DIGIT_MAX  = 4'h9;
  localparam logic [7:0] DEC_STEP   = 8'h01;

  // Decode stage register contents
  typedef struct packed {
    alu_op_t    op;
    logic [7:0] a;
    logic [7:0] v;
    logic [7:0] bit_mask;
    logic [3:0] f;
    logic [7:0] add_x;
    logic [7:0] add_y;
    logic       add_cin;
    logic       add_sub;   // carries are borrows
    logic       daa_c;
  } dec_t;

  // Execute stage register contents
  typedef struct packed {
    logic [7:0] result;
    logic [7:0] zsrc;      // byte the zero flag is taken from
    logic       to_acc;
    logic       z_calc;    // 1: Z from zsrc, 0: Z from z_val
    logic       z_val;
    logic       n;
    logic       h;
    logic       c;
  } exe_t;

endpackage

// ----- rtl/alu8f_dec.sv -----
module alu8f_dec (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  alu8f_pkg::alu_op_t in_op,
  input  logic [7:0]       in_a,
  input  logic [7:0]       in_v,
  input  logic [2:0]       in_bi,
  input  logic [3:0]       in_f,
  output logic             out_valid,
  input  logic             out_ready,
  output alu8f_pkg::dec_t  out_data
);
  import alu8f_pkg::*;

  logic       vld;
  dec_t       data;
  dec_t       data_next;
  logic       cin;
  logic       daa_hi;
  logic       daa_lo;
  logic [7:0] daa_corr;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  always_comb begin
    cin    = in_f[FLAG_C];
    daa_hi = cin || (in_a > DAA_LIMIT);
    daa_lo = in_f[FLAG_H] || (in_a[3:0] > DIGIT_MAX);
    if (in_f[FLAG_N]) begin
      daa_corr = (cin ? DAA_HI_ADJ : 8'h00) | (in_f[FLAG_H] ? DAA_LO_ADJ : 8'h00);
    end else begin
      daa_corr = (daa_hi ? DAA_HI_ADJ : 8'h00) | (daa_lo ? DAA_LO_ADJ : 8'h00);
    end

    data_next.op       = in_op;
    data_next.a        = in_a;
    data_next.v        = in_v;
    data_next.bit_mask = 8'h01 << in_bi;
    data_next.f        = in_f;
    data_next.daa_c    = in_f[FLAG_N] ? cin : daa_hi;
    data_next.add_x    = in_a;
    data_next.add_y    = in_v;
    data_next.add_cin  = 1'b0;
    data_next.add_sub  = 1'b0;

    case (in_op)
      OP_ADC: begin
        data_next.add_cin = cin;
      end
      OP_SUB, OP_CP: begin
        data_next.add_y   = ~in_v;
        data_next.add_cin = 1'b1;
        data_next.add_sub = 1'b1;
      end
      OP_SBC: begin
        data_next.add_y   = ~in_v;
        data_next.add_cin = !cin;
        data_next.add_sub = 1'b1;
      end
      OP_INC: begin
        data_next.add_x   = in_v;
        data_next.add_y   = 8'h00;
        data_next.add_cin = 1'b1;
      end
      OP_DEC: begin
        data_next.add_x   = in_v;
        data_next.add_y   = ~DEC_STEP;
        data_next.add_cin = 1'b1;
        data_next.add_sub = 1'b1;
      end
      OP_DAA: begin
        // subtract mode: a - corr as a + ~corr + 1
        data_next.add_y   = in_f[FLAG_N] ? ~daa_corr : daa_corr;
        data_next.add_cin = in_f[FLAG_N];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

// ----- rtl/alu8f_exe.sv -----
module alu8f_exe (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  alu8f_pkg::dec_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output alu8f_pkg::exe_t out_data
);
  import alu8f_pkg::*;

  logic       vld;
  exe_t       data;
  exe_t       data_next;
  logic [4:0] sum_lo;
  logic [4:0] sum_hi;
  logic [7:0] sum;
  logic       h_ar;
  logic       c_ar;
  logic [7:0] a;
  logic [7:0] v;
  logic [3:0] f;
  logic [7:0] r;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  // nibble-split adder gives the half carry directly
  always_comb begin
    sum_lo = {1'b0, in_data.add_x[3:0]} + {1'b0, in_data.add_y[3:0]}
           + {4'b0, in_data.add_cin};
    sum_hi = {1'b0, in_data.add_x[7:4]} + {1'b0, in_data.add_y[7:4]}
           + {4'b0, sum_lo[4]};
    sum    = {sum_hi[3:0], sum_lo[3:0]};
    h_ar   = sum_lo[4] ^ in_data.add_sub;
    c_ar   = sum_hi[4] ^ in_data.add_sub;
  end

  always_comb begin
    a = in_data.a;
    v = in_data.v;
    f = in_data.f;
    r = a;
    data_next.to_acc = 1'b1;
    data_next.z_calc = 1'b0;
    data_next.z_val  = f[FLAG_Z];
    data_next.n      = f[FLAG_N];
    data_next.h      = f[FLAG_H];
    data_next.c      = f[FLAG_C];

    case (in_data.op)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC: begin
        r = sum;
        data_next.z_calc = 1'b1;
        data_next.n      = in_data.add_sub;
        data_next.h      = h_ar;
        data_next.c      = c_ar;
      end
      OP_CP: begin
        data_next.z_calc = 1'b1;
        data_next.n      = 1'b1;
        data_next.h      = h_ar;
        data_next.c      = c_ar;
      end
      OP_AND, OP_XOR, OP_OR: begin
        r = (in_data.op == OP_AND) ? (a & v) : (in_data.op == OP_XOR) ? (a ^ v) : (a | v);
        data_next.z_calc = 1'b1;
        data_next.n      = 1'b0;
        data_next.h      = (in_data.op == OP_AND);
        data_next.c      = 1'b0;
      end
      OP_INC, OP_DEC: begin
        r = sum;
        data_next.to_acc = 1'b0;
        data_next.z_calc = 1'b1;
        data_next.n      = in_data.add_sub;
        data_next.h      = h_ar;
      end
      OP_RLCA, OP_RRCA, OP_RRA: begin
        r = (in_data.op == OP_RLCA) ? {a[6:0], a[7]} :
            (in_data.op == OP_RRCA) ? {a[0], a[7:1]} : {f[FLAG_C], a[7:1]};
        data_next.z_val = 1'b0;
        data_next.n     = 1'b0;
        data_next.h     = 1'b0;
        data_next.c     = (in_data.op == OP_RLCA) ? a[7] : a[0];
      end
      OP_RLC, OP_RL, OP_SLA: begin
        r = (in_data.op == OP_RLC) ? {v[6:0], v[7]} :
            (in_data.op == OP_RL) ? {v[6:0], f[FLAG_C]} : {v[6:0], 1'b0};
        data_next.to_acc = 1'b0;
        data_next.z_calc = 1'b1;
        data_next.n      = 1'b0;
        data_next.h      = 1'b0;
        data_next.c      = v[7];
      end
      OP_RRC, OP_RR, OP_SRA, OP_SRL: begin
        r = (in_data.op == OP_RRC) ? {v[0], v[7:1]} :
            (in_data.op == OP_RR) ? {f[FLAG_C], v[7:1]} :
            (in_data.op == OP_SRA) ? {v[7], v[7:1]} : {1'b0, v[7:1]};
        data_next.to_acc = 1'b0;
        data_next.z_calc = 1'b1;
        data_next.n      = 1'b0;
        data_next.h      = 1'b0;
        data_next.c      = v[0];
      end
      OP_SWAP: begin
        r = {v[3:0], v[7:4]};
        data_next.to_acc = 1'b0;
        data_next.z_calc = 1'b1;
        data_next.n      = 1'b0;
        data_next.h      = 1'b0;
        data_next.c      = 1'b0;
      end
      OP_BIT: begin
        r = v;
        data_next.to_acc = 1'b0;
        data_next.z_val  = ~|(v & in_data.bit_mask);
        data_next.n      = 1'b0;
        data_next.h      = 1'b1;
      end
      OP_RES: begin
        r = v & ~in_data.bit_mask;
        data_next.to_acc = 1'b0;
      end
      OP_SET: begin
        r = v | in_data.bit_mask;
        data_next.to_acc = 1'b0;
      end
      OP_DAA: begin
        r = sum;
        data_next.z_calc = 1'b1;
        data_next.h      = 1'b0;
        data_next.c      = in_data.daa_c;
      end
      OP_CPL: begin
        r = ~a;
        data_next.n = 1'b1;
        data_next.h = 1'b1;
      end
      OP_SCF, OP_CCF: begin
        data_next.n = 1'b0;
        data_next.h = 1'b0;
        data_next.c = (in_data.op == OP_SCF) ? 1'b1 : !f[FLAG_C];
      end
      default: begin
        // spare codes: no operation
      end
    endcase

    data_next.result = r;
    data_next.zsrc   = (in_data.op == OP_CP) ? sum : r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

// ----- rtl/alu8f_wb.sv -----
module alu8f_wb (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  alu8f_pkg::exe_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_result,
  output logic            out_dest_is_acc,
  output logic [3:0]      out_flags
);
  import alu8f_pkg::*;

  logic       vld;
  logic [7:0] result;
  logic       dest_is_acc;
  logic [3:0] flags;
  logic [3:0] flags_next;

  assign in_ready        = !vld || out_ready;
  assign out_valid       = vld;
  assign out_result      = result;
  assign out_dest_is_acc = dest_is_acc;
  assign out_flags       = flags;

  always_comb begin
    flags_next         = 4'h0;
    flags_next[FLAG_Z] = in_data.z_calc ? (in_data.zsrc == 8'h00) : in_data.z_val;
    flags_next[FLAG_N] = in_data.n;
    flags_next[FLAG_H] = in_data.h;
    flags_next[FLAG_C] = in_data.c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result      <= in_data.result;
      dest_is_acc <= in_data.to_acc;
      flags       <= flags_next;
    end
  end

endmodule

// ----- rtl/cpu_alu_8bit_flags.sv -----
// 8-bit ALU with Z N H C flags, three register stages: decode, execute, flag merge.
// An accepted input transaction passes the decode, execute and flag merge registers to m_axis.
// Throughput: one transaction per cycle; each stage holds one item and moves on
// whenever the stage after it is empty or being drained.
// Reset (rst, synchronous, active high) empties all stages; no other state.
module cpu_alu_8bit_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] kind, [12:5] acc, [20:13] operand, [23:21] bit_index,
  // [27:24] flags_in, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] result, [8] dest_is_acc, [12:9] flags_out, [15:13] zero
  output logic [15:0] m_axis_tdata
);
  import alu8f_pkg::*;

  // stage handshakes
  logic s1_vld;
  logic s1_ready;
  logic s2_vld;
  logic s2_ready;
  dec_t s1_data;
  exe_t s2_data;

  logic [7:0] result;
  logic       dest_is_acc;
  logic [3:0] flags_out;

  // Stage 1: operation decode, adder operand set-up, decimal adjust correction
  alu8f_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (alu_op_t'(s_axis_tdata[4:0])),
    .in_a      (s_axis_tdata[12:5]),
    .in_v      (s_axis_tdata[20:13]),
    .in_bi     (s_axis_tdata[23:21]),
    .in_f      (s_axis_tdata[27:24]),
    .out_valid (s1_vld),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  // Stage 2: shared add/subtract, logic, rotates and bit operations
  alu8f_exe u_exe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_vld),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_vld),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // Stage 3: zero detect and flag merge into the output register
  alu8f_wb u_wb (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s2_vld),
    .in_ready        (s2_ready),
    .in_data         (s2_data),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_result      (result),
    .out_dest_is_acc (dest_is_acc),
    .out_flags       (flags_out)
  );

  assign m_axis_tdata = {3'b000, flags_out, dest_is_acc, result};

`ifndef SYNTHESIS
  // a draining output never blocks the input side
  assert property (@(posedge clk) disable iff (rst) m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // an accepted transaction lands in stage 1
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> s1_vld)
    else $error("accepted transaction lost in stage 1");

  // a transaction leaving stage 2 lands in the output register
  assert property (@(posedge clk) disable iff (rst)
    (s2_vld && s2_ready) |=> m_axis_tvalid)
    else $error("transaction lost between stage 2 and output");

  // an empty pipeline always accepts
  assert property (@(posedge clk) disable iff (rst)
    (!s1_vld && !s2_vld && !m_axis_tvalid) |-> s_axis_tready)
    else $error("empty pipeline refused input");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import alu8f_pkg::*;

  // One result transaction as it leaves the ALU
  typedef struct packed {
    logic [7:0] result;
    logic       dest_is_acc;
    logic [3:0] flags_out;   // Z N H C, bit 3 down to bit 0
  } alu_outcome_t;

  // Codes 28..31 are not operations; the ALU passes acc and flags through
  localparam logic [4:0] FIRST_UNUSED_OP = 5'd28;
  localparam logic [4:0] LAST_UNUSED_OP  = 5'd31;

  localparam int unsigned ITEMS_PER_PHASE = 325;
  localparam int unsigned NUM_PHASES      = 4;
  localparam int unsigned DRAIN_CYCLES    = 8;   // pipeline is three stages deep

  // Scoreboard: predicts each accepted operation and checks the results in order
  class flag_alu_scoreboard;
    alu_outcome_t pending_outcomes[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endfunction

    // Field layout of s_axis_tdata: kind, acc, operand, bit_index, flags_in
    function alu_outcome_t alu_outcome(logic [31:0] item);
      logic [4:0]   code;
      logic [7:0]   a, v, r, t;
      logic [2:0]   bi;
      logic [3:0]   f, nf;
      logic         cin, c, co, to_acc;
      logic [8:0]   wide;
      logic [4:0]   nib;
      alu_outcome_t o;
      code   = item[4:0];
      a      = item[12:5];
      v      = item[20:13];
      bi     = item[23:21];
      f      = item[27:24];
      cin    = f[FLAG_C];
      r      = a;
      to_acc = 1'b1;
      nf     = f;
      c      = 1'b0;
      co     = 1'b0;
      case (alu_op_t'(code))
        OP_ADD, OP_ADC: begin
          c    = (alu_op_t'(code) == OP_ADC) ? cin : 1'b0;
          wide = {1'b0, a} + {1'b0, v} + {8'd0, c};
          nib  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
          r    = wide[7:0];
          nf   = {r == 8'd0, 1'b0, nib[4], wide[8]};
        end
        OP_SUB, OP_SBC, OP_CP: begin
          // borrows out of bit 8 and bit 4 are the carry and half carry
          c    = (alu_op_t'(code) == OP_SBC) ? cin : 1'b0;
          wide = {1'b0, a} - {1'b0, v} - {8'd0, c};
          nib  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, c};
          t    = wide[7:0];
          nf   = {t == 8'd0, 1'b1, nib[4], wide[8]};
          r    = (alu_op_t'(code) == OP_CP) ? a : t;
        end
        OP_AND: begin
          r  = a & v;
          nf = {r == 8'd0, 1'b0, 1'b1, 1'b0};
        end
        OP_XOR: begin
          r  = a ^ v;
          nf = {r == 8'd0, 3'b000};
        end
        OP_OR: begin
          r  = a | v;
          nf = {r == 8'd0, 3'b000};
        end
        OP_INC: begin
          r      = v + 8'd1;
          to_acc = 1'b0;
          nf     = {r == 8'd0, 1'b0, v[3:0] == 4'hF, cin};
        end
        OP_DEC: begin
          r      = v - 8'd1;
          to_acc = 1'b0;
          nf     = {r == 8'd0, 1'b1, v[3:0] == 4'h0, cin};
        end
        // accumulator rotates always clear Z
        OP_RLCA: begin
          r  = {a[6:0], a[7]};
          nf = {3'b000, a[7]};
        end
        OP_RRCA: begin
          r  = {a[0], a[7:1]};
          nf = {3'b000, a[0]};
        end
        OP_RRA: begin
          r  = {cin, a[7:1]};
          nf = {3'b000, a[0]};
        end
        OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL, OP_SWAP: begin
          to_acc = 1'b0;
          case (alu_op_t'(code))
            OP_RLC:  begin r = {v[6:0], v[7]}; co = v[7]; end
            OP_RRC:  begin r = {v[0], v[7:1]}; co = v[0]; end
            OP_RL:   begin r = {v[6:0], cin};  co = v[7]; end
            OP_RR:   begin r = {cin, v[7:1]};  co = v[0]; end
            OP_SLA:  begin r = {v[6:0], 1'b0}; co = v[7]; end
            OP_SRA:  begin r = {v[7], v[7:1]}; co = v[0]; end
            OP_SRL:  begin r = {1'b0, v[7:1]}; co = v[0]; end
            default: begin r = {v[3:0], v[7:4]}; co = 1'b0; end
          endcase
          nf = {r == 8'd0, 2'b00, co};
        end
        OP_BIT: begin
          r      = v;
          to_acc = 1'b0;
          nf     = {~v[bi], 1'b0, 1'b1, cin};
        end
        OP_RES: begin
          r      = v & ~(8'd1 << bi);
          to_acc = 1'b0;
        end
        OP_SET: begin
          r      = v | (8'd1 << bi);
          to_acc = 1'b0;
        end
        OP_DAA: begin
          t = a;
          c = cin;
          if (f[FLAG_N]) begin
            if (cin) t = t - DAA_HI_ADJ;
            if (f[FLAG_H]) t = t - DAA_LO_ADJ;
          end else begin
            if (cin || t > DAA_LIMIT) begin
              t = t + DAA_HI_ADJ;
              c = 1'b1;
            end
            if (f[FLAG_H] || t[3:0] > DIGIT_MAX) t = t + DAA_LO_ADJ;
          end
          r  = t;
          nf = {r == 8'd0, f[FLAG_N], 1'b0, c};
        end
        OP_CPL: begin
          r  = ~a;
          nf = {f[FLAG_Z], 1'b1, 1'b1, f[FLAG_C]};
        end
        OP_SCF: nf = {f[FLAG_Z], 2'b00, 1'b1};
        OP_CCF: nf = {f[FLAG_Z], 2'b00, ~cin};
        default: ;  // unused code: nothing changes
      endcase
      o.result      = r;
      o.dest_is_acc = to_acc;
      o.flags_out   = nf;
      return o;
    endfunction

    function void note_operation(logic [31:0] item);
      pending_outcomes.push_back(alu_outcome(item));
    endfunction

    function void check_outcome(logic [15:0] word);
      alu_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report($sformatf("unexpected result transaction %h", word));
        return;
      end
      want = pending_outcomes.pop_front();
      if (word[7:0] !== want.result)
        report($sformatf("result %h, expected %h", word[7:0], want.result));
      if (word[8] !== want.dest_is_acc)
        report($sformatf("dest_is_acc %b, expected %b", word[8], want.dest_is_acc));
      if (word[12:9] !== want.flags_out)
        report($sformatf("flags_out %b, expected %b", word[12:9], want.flags_out));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [4:0] kind, [12:5] acc, [20:13] operand, [23:21] bit_index,
  // [27:24] flags_in, [31:28] zero
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] result, [8] dest_is_acc, [12:9] flags_out, [15:13] zero
  logic [15:0] m_axis_tdata;

  // Idle and stall chances, in percent per cycle
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  flag_alu_scoreboard sb;

  cpu_alu_8bit_flags dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] pack_op(logic [4:0] code, logic [7:0] a, logic [7:0] v,
                                          logic [2:0] bi, logic [3:0] f);
    return {4'b0000, f, bi, v, a, code};
  endfunction

  // Mostly uniform bytes, with a share of nibble and BCD boundaries
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [10];
    corners = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'h9A, 8'hF0, 8'hFF};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 9)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] random_op();
    logic [4:0] code;
    if ($urandom_range(0, 99) < 3)
      code = 5'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
    else
      code = 5'($urandom_range(OP_ADD, OP_CCF));
    return pack_op(code, pick_byte(), pick_byte(), 3'($urandom_range(0, 7)),
                   4'($urandom_range(0, 15)));
  endfunction

  // Offer one input transaction, idling first at the current rate.
  // tvalid stays up from one transaction to the next when no idle is drawn.
  task automatic send_op(input logic [31:0] item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_operation(item);
  endtask

  // Result side: values read here are those before the edge, as the DUT saw them
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_outcome(m_axis_tdata);
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    logic [31:0] directed [$];
    sb = new();
    // flag corners of each operation, including the special cases:
    // compare keeps acc, bit test keeps carry, res/set keep all flags,
    // accumulator rotates clear Z, DAA in both modes, unused codes pass through
    directed = '{
      pack_op(OP_ADD,  8'hFF, 8'h01, 3'd0, 4'b0000),
      pack_op(OP_ADC,  8'h0F, 8'h00, 3'd0, 4'b0001),
      pack_op(OP_SUB,  8'h3C, 8'h3C, 3'd0, 4'b0000),
      pack_op(OP_SBC,  8'h00, 8'h00, 3'd0, 4'b0001),
      pack_op(OP_AND,  8'hF0, 8'h0F, 3'd0, 4'b1111),
      pack_op(OP_XOR,  8'hFF, 8'hFF, 3'd0, 4'b0000),
      pack_op(OP_OR,   8'h00, 8'h00, 3'd0, 4'b0111),
      pack_op(OP_CP,   8'h10, 8'h20, 3'd0, 4'b0000),
      pack_op(OP_INC,  8'h00, 8'hFF, 3'd0, 4'b0001),
      pack_op(OP_DEC,  8'h00, 8'h10, 3'd0, 4'b0000),
      pack_op(OP_RLCA, 8'h80, 8'h00, 3'd0, 4'b1111),
      pack_op(OP_RRCA, 8'h01, 8'h00, 3'd0, 4'b1000),
      pack_op(OP_RRA,  8'h00, 8'h00, 3'd0, 4'b1001),
      pack_op(OP_RLC,  8'h00, 8'h00, 3'd0, 4'b0111),
      pack_op(OP_RRC,  8'h00, 8'h01, 3'd0, 4'b0000),
      pack_op(OP_RL,   8'h00, 8'h80, 3'd0, 4'b0000),
      pack_op(OP_RR,   8'h00, 8'h01, 3'd0, 4'b0001),
      pack_op(OP_SLA,  8'h00, 8'hFF, 3'd0, 4'b0000),
      pack_op(OP_SRA,  8'h00, 8'h81, 3'd0, 4'b0000),
      pack_op(OP_SRL,  8'h00, 8'h01, 3'd0, 4'b1110),
      pack_op(OP_SWAP, 8'h00, 8'hF0, 3'd0, 4'b0001),
      pack_op(OP_BIT,  8'h00, 8'h7F, 3'd7, 4'b0101),
      pack_op(OP_RES,  8'h00, 8'hFF, 3'd0, 4'b1010),
      pack_op(OP_SET,  8'h00, 8'h00, 3'd7, 4'b0101),
      pack_op(OP_DAA,  8'h9A, 8'h00, 3'd0, 4'b0000),
      pack_op(OP_DAA,  8'h00, 8'h00, 3'd0, 4'b0111),
      pack_op(OP_CPL,  8'h55, 8'h00, 3'd0, 4'b1001),
      pack_op(OP_SCF,  8'hFF, 8'h00, 3'd0, 4'b0110),
      pack_op(OP_CCF,  8'h00, 8'hFF, 3'd0, 4'b1111),
      pack_op(LAST_UNUSED_OP, 8'hA5, 8'h5A, 3'd5, 4'b1010)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_op(directed[i]);

    // phases: no idling, idle sender, stalling receiver, both at once
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 86; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 86; end
        default: begin send_idle_pct <= 31; recv_stall_pct <= 31; end
      endcase
      repeat (ITEMS_PER_PHASE) send_op(random_op());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", sb.pending_outcomes.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ----- cpu_alu_8bit_flags.f -----
rtl/alu8f_pkg.sv
rtl/alu8f_dec.sv
rtl/alu8f_exe.sv
rtl/alu8f_wb.sv
rtl/cpu_alu_8bit_flags.sv
test/testbench.sv
